/* rtl/core/ucb_pkg.sv */
// Shared types and constants for the UCB1 child selector.
// Used by ucb_alu, ucb1_child_selector and tb_top; depends on nothing else.
package ucb_pkg;

  // Action codes carried in the input item's op field.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_RECORD = 2'd2;
  localparam logic [1:0] OP_BEST   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MOVE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_EXPLORE_GAIN = 2'd1;
  localparam logic [1:0] CFG_ROOT_PLAYER  = 2'd2;

  // Operations of the shared arithmetic unit.
  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  // Dividends are at most 48 bits wide, square root operands 64 bits.
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 32;

  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [31:0] SCORE_INF = 32'hFFFF_FFFF;
  localparam logic [31:0] SCORE_CAP = 32'hFFFF_FFFE;
  localparam logic [15:0] GAIN_RESET = 16'd5793;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] opa;
    logic [31:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

endpackage

/* rtl/core/ucb_alu.sv */
// Shared arithmetic unit: 32x32 multiply with a registered result, bit-serial
// divide and bit-serial square root. Depends on ucb_pkg.
module ucb_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  ucb_pkg::alu_req_t req,
  output ucb_pkg::alu_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [1:0]  op_r;
  logic [63:0] acc_r;
  logic [34:0] rem_r;
  logic [63:0] q_r;
  logic [31:0] b_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] rem_nxt;
  logic [63:0] acc_nxt;
  logic [63:0] prod;

  logic load;
  assign load = req.start && !busy_r;
  assign prod = req.opa[31:0] * req.opb;

  always_comb begin
    if (op_r == ucb_pkg::ALU_SQRT) begin
      rem_sh  = {rem_r[32:0], acc_r[63:62]};
      trial   = {1'b0, q_r[31:0], 2'b01};
      acc_nxt = {acc_r[61:0], 2'b00};
    end else begin
      rem_sh  = {rem_r[33:0], acc_r[ucb_pkg::DIV_STEPS-1]};
      trial   = {3'b000, b_r};
      acc_nxt = {acc_r[62:0], 1'b0};
    end
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        case (req.op)
          ucb_pkg::ALU_DIV: begin
            busy_r <= 1'b1;
            cnt_r  <= 6'(ucb_pkg::DIV_STEPS);
          end
          ucb_pkg::ALU_SQRT: begin
            busy_r <= 1'b1;
            cnt_r  <= 6'(ucb_pkg::SQRT_STEPS);
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r  <= req.op;
      b_r   <= req.opb;
      acc_r <= req.opa;
      rem_r <= '0;
      q_r   <= (req.op == ucb_pkg::ALU_MUL) ? prod : 64'd0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = q_r;

endmodule

/* rtl/core/ucb1_child_selector.sv */
// UCB1 child selector: counter store, sequencer and result register.
// Depends on ucb_pkg and ucb_alu.
// Items are taken one at a time. Record reads and then writes the store; clear
// makes a pass over the whole store. Select first takes ln of the root visits by
// normalising and repeated squaring, then reads each move; for a visited one the
// shared unit's bit-serial divider runs twice, then its bit-serial square root.
// Best reads each move, compares visited ones by products, then divides once.
// Reset: a clearing pass over all MAX_MOVES entries zeroes the store; no item is
// accepted until it ends. Configuration writes are taken at any time.
module ucb1_child_selector #(
  parameter int MAX_MOVES  = 128,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] move_index, [7] winner
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [6:0] chosen_move, [7] status, [39:8] score
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_MOVES);
  localparam int NW = $clog2(MAX_MOVES + 1);
  localparam int CB = COUNT_BITS;
  localparam logic [CB-1:0] COUNT_MAX = '1;

  // Sequencer states.
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_LN_NORM = 5'd2;
  localparam logic [4:0] S_LN_SQ   = 5'd3;
  localparam logic [4:0] S_LN_SQW  = 5'd4;
  localparam logic [4:0] S_LN_MUL  = 5'd5;
  localparam logic [4:0] S_LN_MULW = 5'd6;
  localparam logic [4:0] S_SEL_RD  = 5'd7;
  localparam logic [4:0] S_SEL_EV  = 5'd8;
  localparam logic [4:0] S_SEL_RAT = 5'd9;
  localparam logic [4:0] S_SEL_T   = 5'd10;
  localparam logic [4:0] S_SEL_SQ  = 5'd11;
  localparam logic [4:0] S_SEL_GM  = 5'd12;
  localparam logic [4:0] S_BST_RD  = 5'd13;
  localparam logic [4:0] S_BST_EV  = 5'd14;
  localparam logic [4:0] S_BST_M1  = 5'd15;
  localparam logic [4:0] S_BST_M2  = 5'd16;
  localparam logic [4:0] S_BST_RAT = 5'd17;
  localparam logic [4:0] S_REC_RD  = 5'd18;
  localparam logic [4:0] S_REC_WR  = 5'd19;
  localparam logic [4:0] S_DONE    = 5'd20;

  // Caps a quotient or sum at the largest finite score.
  function automatic logic [31:0] cap_score(input logic [63:0] x);
    logic [31:0] r;
    if (x > 64'(SCORE_CAP_W)) r = SCORE_CAP_W;
    else r = x[31:0];
    return r;
  endfunction
  localparam logic [31:0] SCORE_CAP_W = ucb_pkg::SCORE_CAP;

  // Configuration registers.
  logic [7:0]  move_count_r;
  logic [15:0] gain_r;
  logic        root_player_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_count_r  <= '0;
      gain_r        <= ucb_pkg::GAIN_RESET;
      root_player_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ucb_pkg::CFG_MOVE_COUNT:   move_count_r  <= cfg_data[7:0];
        ucb_pkg::CFG_EXPLORE_GAIN: gain_r        <= cfg_data;
        ucb_pkg::CFG_ROOT_PLAYER:  root_player_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective number of moves: the register, limited to the store depth.
  logic [NW-1:0] n_live;
  assign n_live = (32'(move_count_r) >= MAX_MOVES) ? NW'(MAX_MOVES) : NW'(move_count_r);

  // Sequencer registers.
  logic [4:0]    state_r;
  logic [NW-1:0] clr_i_r;
  logic          clr_reply_r;
  logic [NW-1:0] i_r;
  logic          found_r;
  logic [AW-1:0] pick_r;
  logic [31:0]   best_score_r;
  logic [CB-1:0] bw_r;
  logic [CB-1:0] bv_r;
  logic [63:0]   p1_r;
  logic [31:0]   ratio_r;
  logic [31:0]   root_visits_r;
  logic [31:0]   y_r;
  logic [4:0]    e_r;
  logic [15:0]   frac_r;
  logic [3:0]    k_r;
  logic [31:0]   ln_r;
  logic [6:0]    idx_r;
  logic          winner_r;

  // Result waiting for the output register.
  logic [6:0]    res_move_r;
  logic          res_status_r;
  logic [31:0]   res_score_r;

  // Output register.
  logic          out_valid_r;
  logic [6:0]    out_move_r;
  logic          out_status_r;
  logic [31:0]   out_score_r;

  // Shared unit request, registered in the state that asks for it.
  logic          alu_start_r;
  logic [1:0]    alu_op_r;
  logic [63:0]   alu_opa_r;
  logic [31:0]   alu_opb_r;
  ucb_pkg::alu_req_t alu_req;
  ucb_pkg::alu_rsp_t alu_rsp;

  assign alu_req.start = alu_start_r;
  assign alu_req.op    = alu_op_r;
  assign alu_req.opa   = alu_opa_r;
  assign alu_req.opb   = alu_opb_r;

  ucb_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // Counter store: wins in the upper half of a word, visits in the lower.
  logic [2*CB-1:0] mem [MAX_MOVES];
  logic [2*CB-1:0] rd_data_r;
  logic [AW-1:0]   raddr;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [2*CB-1:0] wdata;
  logic [31:0]     idx_ext;
  logic [AW-1:0]   idx_addr;

  assign idx_ext  = 32'(idx_r);
  assign idx_addr = idx_ext[AW-1:0];

  logic [CB-1:0] cur_v;
  logic [CB-1:0] cur_w;
  logic [CB-1:0] v_inc;
  logic [CB-1:0] w_inc;
  assign cur_v = rd_data_r[CB-1:0];
  assign cur_w = rd_data_r[2*CB-1:CB];
  assign v_inc = (cur_v == COUNT_MAX) ? cur_v : cur_v + 1'b1;
  assign w_inc = (winner_r == root_player_r && cur_w != COUNT_MAX) ? cur_w + 1'b1 : cur_w;

  always_comb begin
    raddr  = (state_r == S_REC_RD || state_r == S_REC_WR) ? idx_addr : i_r[AW-1:0];
    mem_we = 1'b0;
    waddr  = clr_i_r[AW-1:0];
    wdata  = '0;
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
    end else if (state_r == S_REC_WR) begin
      mem_we = 1'b1;
      waddr  = idx_addr;
      wdata  = {w_inc, v_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  // Score of the current visited move, once the gain product is back.
  logic [63:0] sel_total;
  logic [31:0] sel_score;
  assign sel_total = 64'(ratio_r) + 64'(alu_rsp.res[47:12]);
  assign sel_score = cap_score(sel_total);

  logic [31:0] pick_ext;
  assign pick_ext = 32'(pick_r);

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_i_r     <= '0;
      clr_reply_r <= 1'b0;
      alu_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alu_start_r <= 1'b0;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          root_visits_r <= '0;
          clr_i_r       <= clr_i_r + 1'b1;
          if (clr_i_r == NW'(MAX_MOVES - 1)) begin
            res_move_r   <= '0;
            res_status_r <= 1'b0;
            res_score_r  <= '0;
            state_r      <= clr_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            idx_r    <= in_tdata[6:0];
            winner_r <= in_tdata[7];
            i_r      <= '0;
            found_r  <= 1'b0;
            res_move_r   <= '0;
            res_status_r <= 1'b1;
            res_score_r  <= '0;
            case (in_tuser)
              ucb_pkg::OP_CLEAR: begin
                clr_i_r     <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLR;
              end
              ucb_pkg::OP_SELECT: begin
                if (n_live == '0) begin
                  state_r <= S_DONE;
                end else if (root_visits_r < 32'd2) begin
                  ln_r    <= '0;
                  state_r <= S_SEL_RD;
                end else begin
                  y_r     <= root_visits_r;
                  e_r     <= 5'd31;
                  frac_r  <= '0;
                  k_r     <= '0;
                  state_r <= S_LN_NORM;
                end
              end
              ucb_pkg::OP_RECORD: begin
                if (32'(in_tdata[6:0]) < 32'(n_live)) state_r <= S_REC_RD;
                else state_r <= S_DONE;
              end
              default: begin
                state_r <= S_BST_RD;
              end
            endcase
          end
        end
        S_LN_NORM: begin
          if (y_r[31]) begin
            state_r <= S_LN_SQ;
          end else begin
            y_r <= {y_r[30:0], 1'b0};
            e_r <= e_r - 5'd1;
          end
        end
        S_LN_SQ: begin
          alu_start_r <= 1'b1;
          alu_op_r    <= ucb_pkg::ALU_MUL;
          alu_opa_r   <= 64'(y_r);
          alu_opb_r   <= y_r;
          state_r     <= S_LN_SQW;
        end
        S_LN_SQW: begin
          if (alu_rsp.done) begin
            // Squared mantissa back in Q1.31; a carry into bit 32 is a
            // fraction bit of one and halves the mantissa.
            if (alu_rsp.res[63]) begin
              y_r    <= alu_rsp.res[63:32];
              frac_r <= {frac_r[14:0], 1'b1};
            end else begin
              y_r    <= alu_rsp.res[62:31];
              frac_r <= {frac_r[14:0], 1'b0};
            end
            k_r <= k_r + 4'd1;
            state_r <= (k_r == 4'd15) ? S_LN_MUL : S_LN_SQ;
          end
        end
        S_LN_MUL: begin
          alu_start_r <= 1'b1;
          alu_op_r    <= ucb_pkg::ALU_MUL;
          alu_opa_r   <= 64'({e_r, frac_r});
          alu_opb_r   <= 32'(ucb_pkg::LN2_Q16);
          state_r     <= S_LN_MULW;
        end
        S_LN_MULW: begin
          if (alu_rsp.done) begin
            ln_r    <= alu_rsp.res[47:16];
            state_r <= S_SEL_RD;
          end
        end
        S_SEL_RD: begin
          if (i_r == n_live) begin
            res_move_r   <= pick_ext[6:0];
            res_status_r <= 1'b0;
            res_score_r  <= best_score_r;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SEL_EV;
          end
        end
        S_SEL_EV: begin
          if (cur_v == '0) begin
            // An unvisited move scores infinite.
            if (!found_r || ucb_pkg::SCORE_INF > best_score_r) begin
              found_r      <= 1'b1;
              best_score_r <= ucb_pkg::SCORE_INF;
              pick_r       <= i_r[AW-1:0];
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_SEL_RD;
          end else begin
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_DIV;
            alu_opa_r   <= 64'(cur_w) << 16;
            alu_opb_r   <= 32'(cur_v);
            state_r     <= S_SEL_RAT;
          end
        end
        S_SEL_RAT: begin
          if (alu_rsp.done) begin
            ratio_r     <= cap_score(alu_rsp.res);
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_DIV;
            alu_opa_r   <= 64'(ln_r) << 16;
            alu_opb_r   <= 32'(cur_v);
            state_r     <= S_SEL_T;
          end
        end
        S_SEL_T: begin
          if (alu_rsp.done) begin
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_SQRT;
            alu_opa_r   <= {alu_rsp.res[47:0], 16'h0000};
            alu_opb_r   <= '0;
            state_r     <= S_SEL_SQ;
          end
        end
        S_SEL_SQ: begin
          if (alu_rsp.done) begin
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_MUL;
            alu_opa_r   <= 64'(alu_rsp.res[31:0]);
            alu_opb_r   <= 32'(gain_r);
            state_r     <= S_SEL_GM;
          end
        end
        S_SEL_GM: begin
          if (alu_rsp.done) begin
            if (!found_r || sel_score > best_score_r) begin
              found_r      <= 1'b1;
              best_score_r <= sel_score;
              pick_r       <= i_r[AW-1:0];
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_SEL_RD;
          end
        end
        S_BST_RD: begin
          if (i_r == n_live) begin
            if (found_r) begin
              alu_start_r <= 1'b1;
              alu_op_r    <= ucb_pkg::ALU_DIV;
              alu_opa_r   <= 64'(bw_r) << 16;
              alu_opb_r   <= 32'(bv_r);
              state_r     <= S_BST_RAT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_BST_EV;
          end
        end
        S_BST_EV: begin
          if (cur_v == '0) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_BST_RD;
          end else if (!found_r) begin
            found_r <= 1'b1;
            pick_r  <= i_r[AW-1:0];
            bw_r    <= cur_w;
            bv_r    <= cur_v;
            i_r     <= i_r + 1'b1;
            state_r <= S_BST_RD;
          end else begin
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_MUL;
            alu_opa_r   <= 64'(cur_w);
            alu_opb_r   <= 32'(bv_r);
            state_r     <= S_BST_M1;
          end
        end
        S_BST_M1: begin
          if (alu_rsp.done) begin
            p1_r        <= alu_rsp.res;
            alu_start_r <= 1'b1;
            alu_op_r    <= ucb_pkg::ALU_MUL;
            alu_opa_r   <= 64'(bw_r);
            alu_opb_r   <= 32'(cur_v);
            state_r     <= S_BST_M2;
          end
        end
        S_BST_M2: begin
          if (alu_rsp.done) begin
            // Strictly better ratio only, so ties keep the lower index.
            if (p1_r > alu_rsp.res) begin
              pick_r <= i_r[AW-1:0];
              bw_r   <= cur_w;
              bv_r   <= cur_v;
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_BST_RD;
          end
        end
        S_BST_RAT: begin
          if (alu_rsp.done) begin
            res_move_r   <= pick_ext[6:0];
            res_status_r <= 1'b0;
            res_score_r  <= cap_score(alu_rsp.res);
            state_r      <= S_DONE;
          end
        end
        S_REC_RD: begin
          state_r <= S_REC_WR;
        end
        S_REC_WR: begin
          if (root_visits_r != 32'hFFFF_FFFF) root_visits_r <= root_visits_r + 32'd1;
          res_status_r <= 1'b0;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_move_r   <= res_move_r;
            out_status_r <= res_status_r;
            out_score_r  <= res_score_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_score_r, out_status_r, out_move_r};

  // The shared unit is only asked for work when it has finished the last job.
  a_alu_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    alu_start_r |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  // A finished job must land in a state that waits for it.
  a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_LN_SQW || state_r == S_LN_MULW ||
                      state_r == S_SEL_RAT || state_r == S_SEL_T ||
                      state_r == S_SEL_SQ || state_r == S_SEL_GM ||
                      state_r == S_BST_M1 || state_r == S_BST_M2 ||
                      state_r == S_BST_RAT))
    else $error("shared unit result arrived outside a waiting state");

  // The clearing pass zeroes the root counter.
  a_clear_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |=> (root_visits_r == 32'd0))
    else $error("root visits not cleared");

  // An error result carries no move and no score.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_score_r == 32'd0 && out_move_r == 7'd0))
    else $error("error result with move or score");

  // No item is taken while the shared unit still works.
  a_ready_idle_alu: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !alu_rsp.busy)
    else $error("ready while arithmetic in flight");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the UCB1 child selector.
// Depends on ucb_pkg and the ucb1_child_selector RTL; it reads no files.
`timescale 1ns / 1ps

module tb_top;
  import ucb_pkg::*;

  localparam int NMOVES = 128;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [23:0] VISIT_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [6:0]  move;
    logic        status;
    logic [31:0] score;
  } pick_t;

  // A directed row is either one input item or one register write.
  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [6:0]  idx;
    logic        winner;
    logic [15:0] wdata;
    bit          typed;
    pick_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the counter store and registers.
  logic [23:0] visits_m [NMOVES];
  logic [23:0] wins_m [NMOVES];
  logic [31:0] root_m;
  logic [7:0]  move_count_m;
  logic [15:0] gain_m;
  logic        player_m;

  pick_t       pending_picks [$];
  row_t        rows [$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  ucb1_child_selector u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Natural log of the root visit count in Q16.16, via log2 by squaring.
  function automatic logic [31:0] ln_fix(logic [31:0] x);
    int              e;
    longint unsigned y;
    logic [31:0]     fr;
    longint unsigned l2;
    if (x < 2) return '0;
    e = 31;
    while (!x[e]) e--;
    y = 64'(x) << (31 - e);
    fr = '0;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 31;
      fr = {fr[30:0], 1'b0};
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        fr[0] = 1'b1;
      end
    end
    l2 = (64'(e) << 16) | 64'(fr);
    return 32'((l2 * 64'(LN2_Q16)) >> 16);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] win_ratio(logic [23:0] w, logic [23:0] v);
    longint unsigned q;
    if (v == 0) return '0;
    q = (64'(w) << 16) / 64'(v);
    return (q > 64'(SCORE_CAP)) ? SCORE_CAP : q[31:0];
  endfunction

  // Applies one item to the shadow store and returns the result it causes.
  function automatic pick_t apply_item(logic [1:0] op, logic [6:0] idx, logic w);
    pick_t           r;
    int              n;
    bit              found;
    logic [31:0]     lr;
    logic [31:0]     sc;
    longint unsigned t;
    longint unsigned tot;
    r = '0;
    found = 1'b0;
    n = (move_count_m > NMOVES) ? NMOVES : int'(move_count_m);
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NMOVES; i++) begin
          visits_m[i] = '0;
          wins_m[i] = '0;
        end
        root_m = '0;
      end
      OP_SELECT: begin
        lr = ln_fix(root_m);
        for (int i = 0; i < n; i++) begin
          if (visits_m[i] == 0) begin
            sc = SCORE_INF;
          end else begin
            t = (64'(lr) << 16) / 64'(visits_m[i]);
            tot = 64'(win_ratio(wins_m[i], visits_m[i])) +
                  ((64'(gain_m) * sqrt_floor(t << 16)) >> 12);
            sc = (tot > 64'(SCORE_CAP)) ? SCORE_CAP : tot[31:0];
          end
          // Ties keep the lowest index, so only a strictly higher score wins.
          if (!found || sc > r.score) begin
            found = 1'b1;
            r.score = sc;
            r.move = 7'(i);
          end
        end
        if (!found) r.status = 1'b1;
      end
      OP_RECORD: begin
        if (int'(idx) < n) begin
          if (visits_m[idx] < VISIT_MAX) visits_m[idx] = visits_m[idx] + 1;
          if (w == player_m && wins_m[idx] < VISIT_MAX) wins_m[idx] = wins_m[idx] + 1;
          if (root_m != 32'hFFFF_FFFF) root_m = root_m + 1;
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        // Best: exact ratio compare by cross multiplication.
        for (int i = 0; i < n; i++) begin
          if (visits_m[i] != 0) begin
            if (!found || 64'(wins_m[i]) * 64'(visits_m[r.move]) >
                          64'(wins_m[r.move]) * 64'(visits_m[i])) begin
              found = 1'b1;
              r.move = 7'(i);
            end
          end
        end
        if (found) r.score = win_ratio(wins_m[r.move], visits_m[r.move]);
        else r.status = 1'b1;
      end
    endcase
    if (!found && (op == OP_SELECT || op == OP_BEST)) begin
      r.move = '0;
      r.score = '0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [39:0] got, pick_t want);
    $display("mismatch at cycle %0d: %s got move %0d status %0d score %h, want %0d %0d %h",
             cycles, what, got[6:0], got[7], got[39:8], want.move, want.status, want.score);
    errors++;
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_picks.size() == 0) begin
        report("unexpected result", out_tdata, pick_t'('0));
      end else begin
        if (out_tdata[6:0] != pending_picks[0].move) report("chosen_move", out_tdata,
                                                            pending_picks[0]);
        else if (out_tdata[7] != pending_picks[0].status) report("status", out_tdata,
                                                                 pending_picks[0]);
        else if (out_tdata[39:8] != pending_picks[0].score) report("score", out_tdata,
                                                                   pending_picks[0]);
        void'(pending_picks.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  // Offers one item; on acceptance records what the block should answer.
  task automatic send_item(logic [1:0] op, logic [6:0] idx, logic w, bit typed, pick_t want);
    pick_t p;
    int    gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {w, idx};
    do @(posedge clk); while (!in_tready);
    p = apply_item(op, idx, w);
    pending_picks.push_back(typed ? want : p);
    gap = sender_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_MOVE_COUNT:   move_count_m = value[7:0];
      CFG_EXPLORE_GAIN: gain_m = value;
      default:          player_m = value[0];
    endcase
  endtask

  task automatic add_item(logic [1:0] op, logic [6:0] idx, logic w, bit typed,
                          logic [6:0] mv, logic st, logic [31:0] sc);
    row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.idx = idx;
    r.winner = w;
    r.wdata = '0;
    r.typed = typed;
    r.want.move = mv;
    r.want.status = st;
    r.want.score = sc;
    rows.push_back(r);
  endtask

  task automatic add_cfg(logic [1:0] index, logic [15:0] value);
    row_t r;
    r.kind = ROW_CFG;
    r.op = '0;
    r.idx = 7'(index);
    r.winner = 1'b0;
    r.wdata = value;
    r.typed = 1'b0;
    r.want = '0;
    rows.push_back(r);
  endtask

  initial begin
    int n_live;
    int plen;
    logic [1:0]  op;
    logic [6:0]  idx;
    logic [7:0]  mc;
    logic [15:0] gain;
    for (int i = 0; i < NMOVES; i++) begin
      visits_m[i] = '0;
      wins_m[i] = '0;
    end
    root_m = '0;
    move_count_m = '0;
    gain_m = GAIN_RESET;
    player_m = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With no moves configured select and best find nothing
    // and every record is out of range.
    add_item(OP_SELECT, 7'd0,   1'b0, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_BEST,   7'd0,   1'b0, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_RECORD, 7'd0,   1'b1, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_CLEAR,  7'd127, 1'b1, 1, 7'd0, 1'b0, 32'd0);
    add_cfg(CFG_MOVE_COUNT, 16'd4);
    // Everything unvisited: select takes move 0 with an infinite score and
    // best has nothing visited to choose from.
    add_item(OP_SELECT, 7'd0,   1'b0, 1, 7'd0, 1'b0, SCORE_INF);
    add_item(OP_BEST,   7'd0,   1'b0, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_RECORD, 7'd4,   1'b0, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_RECORD, 7'd127, 1'b1, 1, 7'd0, 1'b1, 32'd0);
    add_item(OP_RECORD, 7'd3,   1'b0, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_RECORD, 7'd1,   1'b1, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_SELECT, 7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_item(OP_BEST,   7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_item(OP_RECORD, 7'd0,   1'b0, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_RECORD, 7'd2,   1'b0, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_SELECT, 7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_cfg(CFG_EXPLORE_GAIN, 16'hFFFF);
    add_cfg(CFG_ROOT_PLAYER, 16'hFFFF);
    add_item(OP_RECORD, 7'd1,   1'b1, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_SELECT, 7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_item(OP_BEST,   7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_cfg(CFG_EXPLORE_GAIN, 16'd0);
    add_item(OP_SELECT, 7'd0,   1'b0, 0, '0, 1'b0, '0);
    // A move count above the store size acts as the full store.
    add_cfg(CFG_MOVE_COUNT, 16'hFFFF);
    add_item(OP_RECORD, 7'd127, 1'b1, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_SELECT, 7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_item(OP_BEST,   7'd0,   1'b0, 0, '0, 1'b0, '0);
    add_item(OP_CLEAR,  7'd0,   1'b0, 1, 7'd0, 1'b0, 32'd0);
    add_item(OP_BEST,   7'd0,   1'b0, 1, 7'd0, 1'b1, 32'd0);

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) write_reg(rows[k].idx[1:0], rows[k].wdata);
      else send_item(rows[k].op, rows[k].idx, rows[k].winner, rows[k].typed, rows[k].want);
    end

    // Random part: phases of randomly mixed records, selects, bests and clears.
    for (int ph = 0; ph < 7; ph++) begin
      mc = (ph == 3) ? 8'd128 : (ph == 5) ? 8'(200 + $urandom_range(0, 55))
                              : 8'($urandom_range(1, 12));
      write_reg(CFG_MOVE_COUNT, {8'($urandom), mc});
      gain = (ph == 1) ? 16'hFFFF : (ph == 4) ? 16'd0 : 16'($urandom);
      write_reg(CFG_EXPLORE_GAIN, gain);
      write_reg(CFG_ROOT_PLAYER, 16'($urandom));
      n_live = (mc > NMOVES) ? NMOVES : int'(mc);
      quiet = (ph == 6);
      if (ph == 2) hold_req = 1'b1;
      plen = 20;
      for (int k = 0; k < plen; k++) begin
        case ($urandom_range(0, 19))
          0:             op = OP_CLEAR;
          1, 2, 3, 4:    op = OP_SELECT;
          5, 6, 7:       op = OP_BEST;
          default:       op = OP_RECORD;
        endcase
        // Mostly live moves, a few drawn from the whole index range.
        if ($urandom_range(0, 9) == 0) idx = 7'($urandom);
        else idx = 7'($urandom_range(0, n_live - 1));
        send_item(op, idx, 1'($urandom), 0, pick_t'('0));
        // Once, the sender waits for every result before going on.
        if (ph == 4 && k == 10) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
